@@ hdl/bss_pkg.sv @@
// Shared types, codes and command/status structs for the bounded set store.
package bss_pkg;

    // Default number of stored values
    localparam int CAPACITY_DEF = 64;

    // Width of the count field in a result
    localparam int COUNT_W = 7;

    // Width of a stored value
    localparam int ELEM_W = 32;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_DUP      = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic search;
        logic shift;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic hit;
        logic drained;
        logic remove;
        logic out_busy;
    } sts_t;

endpackage

@@ hdl/bss_if.sv @@
// Valid/ready channel interfaces for requests and results of the bounded set store.
interface bss_req_if;
    logic                                valid;
    logic                                ready;
    bss_pkg::kind_t                      kind;
    logic signed [bss_pkg::ELEM_W-1:0]   elem;

    modport source (output valid, output kind, output elem, input ready);
    modport sink (input valid, input kind, input elem, output ready);
endinterface

interface bss_rsp_if;
    logic                                valid;
    logic                                ready;
    bss_pkg::status_t                    status;
    logic                                is_member;
    logic [bss_pkg::COUNT_W-1:0]         count;

    modport source (output valid, output status, output is_member, output count, input ready);
    modport sink (input valid, input status, input is_member, input count, output ready);
endinterface

@@ hdl/bounded_set_store_core.sv @@
// Top level of the bounded set store: controller, datapath and checks.
// Keeps up to CAPACITY distinct signed 32-bit values in insertion order in a
// single-port-read entry RAM. Each request is an insert, remove, membership
// query or clear, and gives exactly one result with status, the membership
// flag before the operation and the count after it (low 7 bits). One request
// is worked on at a time; the next is taken once the previous one has been
// written to the result register, so a result may wait while a new request
// runs. Timing is set by the linear scan through the entry RAM, one entry per
// cycle with registered read data: a clear skips the scan and goes straight
// to the result register; an insert or query scans the entries in order until
// the value is found or the entries run out, and an unmatched remove scans
// them all. A matching remove stops the scan at the match and carries on
// through the later entries to shift them down one place. A request may also
// wait in its finish step for the result register to be taken. No clearing
// pass is needed after reset; entries beyond the count are never read.
module bounded_set_store_core #(
    parameter int CAPACITY = bss_pkg::CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bss_req_if.sink   req,
    bss_rsp_if.source rsp
);
    import bss_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bss_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_kind      (req.kind),
        .req_elem      (req.elem),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .rsp_status    (rsp.status),
        .rsp_is_member (rsp.is_member),
        .rsp_count     (rsp.count)
    );

    // Only one command at a time
    a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command active");

    // A taken request blocks the next one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while another is in progress");

    // Finishing always presents a result
    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> rsp.valid)
        else $error("finish did not load the result register");

    // Duplicate implies membership, full and not-found imply absence
    a_status_member: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.status == STAT_DUP) == rsp.is_member)
                      || (rsp.status == STAT_OK))
        else $error("status disagrees with membership flag");

endmodule

@@ hdl/bss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/bss_ctrl.sv @@
// Controller state machine sequencing search, shift and finish of each request.
module bss_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  bss_pkg::kind_t req_kind,
    output logic           req_ready,
    output bss_pkg::cmd_t  cmd,
    input  bss_pkg::sts_t  sts
);
    import bss_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (req_kind == KIND_CLEAR) ? S_FINISH : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (sts.hit)
                begin
                    state_next = sts.remove ? S_SHIFT : S_FINISH;
                end
                else if (sts.drained)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.drained)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Hold until the result register is free
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/bss_dp.sv @@
// Datapath: entry RAM, search and shift pointers, count and result register.
module bss_dp #(
    parameter int CAPACITY = bss_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bss_pkg::cmd_t                     cmd,
    output bss_pkg::sts_t                     sts,
    input  bss_pkg::kind_t                    req_kind,
    input  logic signed [bss_pkg::ELEM_W-1:0] req_elem,
    input  logic                              rsp_ready,
    output logic                              rsp_valid,
    output bss_pkg::status_t                  rsp_status,
    output logic                              rsp_is_member,
    output logic [bss_pkg::COUNT_W-1:0]       rsp_count
);
    import bss_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    kind_t                    kind_reg, kind_next;
    logic signed [ELEM_W-1:0] elem_reg, elem_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            ptr_reg, ptr_next;
    logic [CW-1:0]            pos_reg, pos_next;
    logic                     pend_reg, pend_next;
    logic                     found_reg, found_next;
    logic                     out_vld_reg, out_vld_next;
    status_t                  out_status_reg, out_status_next;
    logic                     out_member_reg, out_member_next;
    logic [COUNT_W-1:0]       out_count_reg, out_count_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [ELEM_W-1:0]        ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [ELEM_W-1:0]        ram_rdata;

    logic                     hit;
    logic                     drained;
    logic [CW-1:0]            pos_dec;
    logic [CW-1:0]            count_res;
    status_t                  status_res;

    bss_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Compare the entry read last cycle; pipeline empty with nothing left to read
    assign hit     = pend_reg && (ram_rdata == elem_reg);
    assign drained = !pend_reg && (ptr_reg == count_reg);
    assign pos_dec = pos_reg - ONE_C;

    assign sts.hit      = hit;
    assign sts.drained  = drained;
    assign sts.remove   = (kind_reg == KIND_REMOVE);
    assign sts.out_busy = out_vld_reg && !rsp_ready;

    // Outcome of the request once search and shift are done
    always_comb
    begin
        count_res  = count_reg;
        status_res = STAT_OK;
        case (kind_reg)
            KIND_INSERT:
            begin
                if (found_reg)
                begin
                    status_res = STAT_DUP;
                end
                else if (count_reg == CAP_C)
                begin
                    status_res = STAT_FULL;
                end
                else
                begin
                    count_res = count_reg + ONE_C;
                end
            end
            KIND_REMOVE:
            begin
                if (found_reg)
                begin
                    count_res = count_reg - ONE_C;
                end
                else
                begin
                    status_res = STAT_NOTFOUND;
                end
            end
            KIND_QUERY:
            begin
                status_res = STAT_OK;
            end
            KIND_CLEAR:
            begin
                count_res = '0;
            end
            default:
            begin
                status_res = STAT_OK;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        kind_next       = kind_reg;
        elem_next       = elem_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pos_next        = pos_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        out_status_next = out_status_reg;
        out_member_next = out_member_reg;
        out_count_next  = out_count_reg;
        out_vld_next    = out_vld_reg && !rsp_ready;

        ram_we    = 1'b0;
        ram_waddr = pos_dec[AW-1:0];
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = ptr_reg[AW-1:0];

        // Capture the request and rewind the search
        if (cmd.load)
        begin
            kind_next  = req_kind;
            elem_next  = req_elem;
            ptr_next   = '0;
            pend_next  = 1'b0;
            found_next = 1'b0;
        end

        // Scan entries one per cycle; on a match park the read pointer after it
        if (cmd.search)
        begin
            if (hit)
            begin
                found_next = 1'b1;
                ptr_next   = pos_reg + ONE_C;
                pend_next  = 1'b0;
            end
            else if (ptr_reg < count_reg)
            begin
                ram_re    = 1'b1;
                ptr_next  = ptr_reg + ONE_C;
                pend_next = 1'b1;
                pos_next  = ptr_reg;
            end
            else
            begin
                pend_next = 1'b0;
            end
        end

        // Move each later entry down one place
        if (cmd.shift)
        begin
            if (pend_reg)
            begin
                ram_we = 1'b1;
            end
            if (ptr_reg < count_reg)
            begin
                ram_re    = 1'b1;
                ptr_next  = ptr_reg + ONE_C;
                pend_next = 1'b1;
                pos_next  = ptr_reg;
            end
            else
            begin
                pend_next = 1'b0;
            end
        end

        // Append on an accepted insert, update count and load the result register
        if (cmd.finish)
        begin
            if ((kind_reg == KIND_INSERT) && !found_reg && (count_reg != CAP_C))
            begin
                ram_we    = 1'b1;
                ram_waddr = count_reg[AW-1:0];
                ram_wdata = elem_reg;
            end
            count_next      = count_res;
            out_vld_next    = 1'b1;
            out_status_next = status_res;
            out_member_next = found_reg;
            out_count_next  = COUNT_W'(count_res);
        end
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        elem_reg       <= elem_next;
        pos_reg        <= pos_next;
        out_status_reg <= out_status_next;
        out_member_reg <= out_member_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp_valid     = out_vld_reg;
    assign rsp_status    = out_status_reg;
    assign rsp_is_member = out_member_reg;
    assign rsp_count     = out_count_reg;

endmodule

@@ tb/set_store_checker.sv @@
// Result checker for the bounded set store: predicts every request and compares each result.
module set_store_checker #(
    parameter int CAPACITY = bss_pkg::CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    bss_req_if   req,
    bss_rsp_if   rsp,
    output int   fail_count,
    output int   outstanding,
    output int   results_checked,
    output int   full_rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    import bss_pkg::*;

    typedef struct packed {
        status_t              status;
        logic                 is_member;
        logic [COUNT_W-1:0]   count;
    } set_result_t;

    // Shadow copy of the stored values, kept in insertion order
    logic [ELEM_W-1:0] shadow_values [CAPACITY];
    int                shadow_size;
    set_result_t       predicted_results [$];

    // Apply one request to the shadow set and return the result it should give
    function automatic set_result_t apply_set_op(kind_t op, logic [ELEM_W-1:0] value);
        set_result_t r;
        int          pos;
        pos = shadow_size;
        for (int i = 0; i < shadow_size; i++)
        begin
            if (shadow_values[i] == value && pos == shadow_size)
                pos = i;
        end
        r.status    = STAT_OK;
        r.is_member = (pos < shadow_size);
        case (op)
            KIND_CLEAR:
            begin
                shadow_size = 0;
                r.is_member = 1'b0;
            end
            KIND_INSERT:
            begin
                // a duplicate is reported ahead of a full set
                if (r.is_member)
                    r.status = STAT_DUP;
                else if (shadow_size >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    shadow_values[shadow_size] = value;
                    shadow_size++;
                end
            end
            KIND_REMOVE:
            begin
                if (!r.is_member)
                    r.status = STAT_NOTFOUND;
                else
                begin
                    // close the gap, keeping insertion order
                    for (int i = pos; i + 1 < shadow_size; i++)
                        shadow_values[i] = shadow_values[i + 1];
                    shadow_size--;
                end
            end
            default: ;
        endcase
        r.count = shadow_size[COUNT_W-1:0];
        return r;
    endfunction

    // Compare accepted results, then predict newly accepted requests
    always @(posedge clk or negedge rst_n)
    begin
        set_result_t got;
        set_result_t want;
        if (!rst_n)
        begin
            shadow_size     = 0;
            predicted_results.delete();
            fail_count      = 0;
            results_checked = 0;
            full_rejects    = 0;
            outstanding     = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.status    = rsp.status;
                got.is_member = rsp.is_member;
                got.count     = rsp.count;
                if (predicted_results.size() == 0)
                begin
                    $error("unexpected result: status %0d, is_member %0d, count %0d",
                           got.status, got.is_member, got.count);
                    fail_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    results_checked++;
                    if (got.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, got.status);
                        fail_count++;
                    end
                    if (got.is_member !== want.is_member)
                    begin
                        $error("is_member mismatch: expected %0d, got %0d",
                               want.is_member, got.is_member);
                        fail_count++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("count mismatch: expected %0d, got %0d",
                               want.count, got.count);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                want = apply_set_op(req.kind, req.elem);
                if (want.status == STAT_FULL)
                    full_rejects++;
                predicted_results.push_back(want);
            end
            outstanding = predicted_results.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the bounded set store: clock, reset, request and result traffic, verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bss_pkg::*;

    localparam int CAPACITY        = CAPACITY_DEF;
    localparam int RANDOM_REQUESTS = 1400;
    localparam int POOL_SIZE       = 96;
    localparam int MAX_IDLE        = 13;
    localparam int TAIL_CYCLES     = 2 * CAPACITY + 16;

    typedef enum int {
        FILL_HEAVY,
        DRAIN_HEAVY,
        BALANCED
    } traffic_t;

    logic              clk;
    logic              rst_n;
    bit                no_idle;
    int                fail_count;
    int                outstanding;
    int                results_checked;
    int                full_rejects;
    int                kinds_sent [4];
    logic [ELEM_W-1:0] value_pool [POOL_SIZE];

    bss_req_if req_ch();
    bss_rsp_if rsp_ch();

    bounded_set_store_core #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    set_store_checker #(
        .CAPACITY (CAPACITY)
    ) u_set_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .full_rejects    (full_rejects)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Give up on a hung run
    initial
    begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one request after a random gap and hold it until taken
    task automatic send_request(input kind_t op, input logic [ELEM_W-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= op;
        req_ch.elem  <= value;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        kinds_sent[op]++;
    endtask

    // Mostly reuse pooled values so that hits, duplicates and removals happen
    function automatic logic [ELEM_W-1:0] pick_value();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Weight the operation by the current traffic mix; clears stay rare
    function automatic kind_t pick_kind(traffic_t mix);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll == 0)
            return KIND_CLEAR;
        case (mix)
            FILL_HEAVY:
            begin
                if (roll < 76)
                    return KIND_INSERT;
                if (roll < 88)
                    return KIND_REMOVE;
                return KIND_QUERY;
            end
            DRAIN_HEAVY:
            begin
                if (roll < 16)
                    return KIND_INSERT;
                if (roll < 76)
                    return KIND_REMOVE;
                return KIND_QUERY;
            end
            default:
            begin
                if (roll < 34)
                    return KIND_INSERT;
                if (roll < 67)
                    return KIND_REMOVE;
                return KIND_QUERY;
            end
        endcase
    endfunction

    // Result side: stall at random before each result, sometimes not at all
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
        end
    end

    // Request side: reset, directed cases, random phases, then the verdict
    initial
    begin
        int       sent;
        int       phase_len;
        traffic_t mix;

        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_INSERT;
        req_ch.elem  <= '0;
        no_idle      = 1'b0;

        // Extremes first, then random words and near misses of earlier entries
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        value_pool[4] = 32'h0000_0001;
        value_pool[5] = 32'hFFFF_FFFE;
        for (int i = 6; i < POOL_SIZE; i++)
        begin
            if (i % 4 == 0)
                value_pool[i] = value_pool[$urandom_range(0, i - 1)]
                                ^ (32'd1 << $urandom_range(0, ELEM_W - 1));
            else
                value_pool[i] = $urandom();
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty set: clear, look up and remove with nothing stored
        send_request(KIND_CLEAR,  32'h1234_5678);
        send_request(KIND_QUERY,  32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0005);
        // Fill with the extremes, try duplicates, then look up a stored and a missing value
        send_request(KIND_INSERT, 32'h8000_0000);
        send_request(KIND_INSERT, 32'h7FFF_FFFF);
        send_request(KIND_INSERT, 32'h0000_0000);
        send_request(KIND_INSERT, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'h0000_0001);
        send_request(KIND_INSERT, 32'h7FFF_FFFF);
        send_request(KIND_INSERT, 32'h8000_0000);
        send_request(KIND_QUERY,  32'hFFFF_FFFF);
        send_request(KIND_QUERY,  32'h0000_0002);
        // Remove at the front, the middle and the back, then a missing value; look up and refill
        send_request(KIND_REMOVE, 32'h8000_0000);
        send_request(KIND_REMOVE, 32'h0000_0000);
        send_request(KIND_REMOVE, 32'h0000_0001);
        send_request(KIND_REMOVE, 32'h0000_0001);
        send_request(KIND_QUERY,  32'h8000_0000);
        send_request(KIND_INSERT, 32'h5555_5555);
        send_request(KIND_INSERT, 32'hAAAA_AAAA);
        // Clear a populated set and check it really is empty
        send_request(KIND_CLEAR,  32'hFFFF_FFFF);
        send_request(KIND_QUERY,  32'h5555_5555);
        send_request(KIND_INSERT, 32'h5555_5555);

        // Open with a long fill so the full set is reached early
        sent      = 0;
        mix       = FILL_HEAVY;
        phase_len = 300;
        while (sent < RANDOM_REQUESTS)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            for (int n = 0; n < phase_len && sent < RANDOM_REQUESTS; n++)
            begin
                send_request(pick_kind(mix), pick_value());
                sent++;
            end
            mix       = traffic_t'($urandom_range(0, 2));
            phase_len = $urandom_range(40, 200);
        end
        req_ch.valid <= 1'b0;
        no_idle      = 1'b0;

        // Drain outstanding results, then watch for stragglers
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d inserts, %0d removes, %0d queries and %0d clears",
                 kinds_sent[KIND_INSERT], kinds_sent[KIND_REMOVE],
                 kinds_sent[KIND_QUERY], kinds_sent[KIND_CLEAR]);
        $display("Checked %0d results, %0d of them inserts turned away by a full set",
                 results_checked, full_rejects);
        if (fail_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
hdl/bss_pkg.sv
hdl/bss_if.sv
hdl/bss_ram.sv
hdl/bss_ctrl.sv
hdl/bss_dp.sv
hdl/bounded_set_store_core.sv
tb/set_store_checker.sv
tb/tb_top.sv
